// File: rtl/core/jte_pkg.sv
// ============================================================================
// jte_pkg: shared types and constants for the Julia escape-time pixel block
// Holds the payload word types, register indexes, reset values, fixed-point
// widths and the saturation helper used by the datapath.
// ============================================================================
package jte_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 12;
    localparam int FX_W     = 32;
    localparam int RAD_W    = 31;
    localparam int DIM_W    = 13;
    localparam int PROD_W   = 64;
    localparam int ITER_OUT_W = 5;
    localparam int COLOR_W  = 8;

    // Q4.28 fixed point.
    localparam int FRAC_BITS = 28;

    // Scaling numerator is coord * 2 * R.
    localparam int NUM_W = COORD_W + 1 + RAD_W;

    // Divider: two quotient bits per clock.
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS = (NUM_W + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Wide signed width used ahead of saturation to 32 bits.
    localparam int SAT_W = NUM_W + 2;

    // Colour scale factors.
    localparam int RG_SCALE = 5;
    localparam int B_SCALE  = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_REAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_IMAG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [RAD_W-1:0]        RADIUS_RST = 31'd536870912;
    localparam logic signed [FX_W-1:0]  CREAL_RST  = -32'sd187904819;
    localparam logic signed [FX_W-1:0]  CIMAG_RST  = 32'sd72517838;
    localparam logic [DIM_W-1:0]        FWIDTH_RST  = 13'd1920;
    localparam logic [DIM_W-1:0]        FHEIGHT_RST = 13'd1080;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sh0000_0000_8000_0000);

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [ITER_OUT_W-1:0] iter_count;
        logic                  escaped;
        logic [COLOR_W-1:0]    red;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    blue;
    } result_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [FX_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [FX_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[FX_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[FX_W-1:0];
        end
        else
        begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/julia_escape_time_pixel.sv
// ============================================================================
// julia_escape_time_pixel: Julia-set escape-time evaluator for one pixel
// Maps a pixel to the complex plane, iterates z = z^2 + c in Q4.28 fixed
// point and returns the escape index, an escaped flag and a colour scaled from the index.
// ============================================================================
// A pixel word is taken when start is high and busy is low; busy then stays
// high until the result is out. Setup runs two divisions for the coordinate
// scaling, the multiplier setup and the first three products; each iteration
// then puts three products through the single shared multiplier. The result
// word is shown for exactly one cycle with done high, the first cycle after
// busy falls, and cannot be held off, so the receiver must take it in that
// cycle.
module julia_escape_time_pixel
    import jte_pkg::*;
#(
    parameter int MAX_ITER = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pixel_t               pixel,
    output logic                 busy,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FX_W-1:0]      cfg_data
);

    localparam int ITER_W = $clog2(MAX_ITER + 1);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_MX   = 15'b000000000000010,
        ST_MY   = 15'b000000000000100,
        ST_R2   = 15'b000000000001000,
        ST_CR2  = 15'b000000000010000,
        ST_WX   = 15'b000000000100000,
        ST_DY   = 15'b000000001000000,
        ST_WY   = 15'b000000010000000,
        ST_RR   = 15'b000000100000000,
        ST_II   = 15'b000001000000000,
        ST_RI   = 15'b000010000000000,
        ST_NEW  = 15'b000100000000000,
        ST_NR   = 15'b001000000000000,
        ST_NI   = 15'b010000000000000,
        ST_CHK  = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [RAD_W-1:0]       radius_reg;
    logic signed [FX_W-1:0] creal_reg;
    logic signed [FX_W-1:0] cimag_reg;
    logic [DIM_W-1:0]       fwidth_reg;
    logic [DIM_W-1:0]       fheight_reg;

    // Datapath registers.
    logic [COORD_W-1:0]       px_reg;
    logic [COORD_W-1:0]       py_reg;
    logic [NUM_W-1:0]         numy_reg;
    logic [PROD_W-1:0]        r2_reg;
    logic signed [FX_W-1:0]   zr_reg;
    logic signed [FX_W-1:0]   zi_reg;
    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] d_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic                     done_reg;
    result_t                  result_reg;

    // Shared units.
    logic signed [FX_W-1:0]   mul_a;
    logic signed [FX_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DIM_W-1:0]         div_den;
    logic                     div_done;
    logic [NUM_W-1:0]         div_q;

    logic [FX_W-1:0]          radius_op;
    logic [NUM_W-1:0]         prod_num;
    logic signed [FX_W-1:0]   z0_next;
    logic signed [FX_W-1:0]   zr_next;
    logic signed [FX_W-1:0]   zi_next;
    logic [PROD_W-1:0]        mag;
    logic                     esc_hit;
    logic                     last_iter;
    logic [ITER_W-1:0]        count_v;
    logic [15:0]              count_w;
    logic [15:0]              rg_w;
    logic [15:0]              b_w;

    jte_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    jte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign radius_op = {1'b0, radius_reg};
    assign prod_num  = {prod[NUM_W-2:0], 1'b0};

    // Multiplier operand selection per sequencer step.
    always_comb
    begin
        case (state_reg)
            ST_MX:
            begin
                mul_a = signed'(FX_W'(px_reg));
                mul_b = signed'(radius_op);
            end
            ST_MY:
            begin
                mul_a = signed'(FX_W'(py_reg));
                mul_b = signed'(radius_op);
            end
            ST_R2:
            begin
                mul_a = signed'(radius_op);
                mul_b = signed'(radius_op);
            end
            ST_RR, ST_NR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_II, ST_NI:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            ST_RI, ST_CHK:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The x division starts as soon as its numerator leaves the multiplier.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = prod_num;
        div_den   = (fwidth_reg == '0) ? DIM_W'(1) : fwidth_reg;
        if (state_reg == ST_MY)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == ST_DY)
        begin
            div_start = 1'b1;
            div_num   = numy_reg;
            div_den   = (fheight_reg == '0) ? DIM_W'(1) : fheight_reg;
        end
    end

    // Start value: quotient minus R; it can only overflow upward.
    assign z0_next = sat32(signed'({2'b00, div_q}) - signed'(SAT_W'(radius_reg)));

    // Arithmetic shifts give the floor of the scaled products.
    assign zr_next = sat32(SAT_W'(d_reg >>> FRAC_BITS) + SAT_W'(creal_reg));
    assign zi_next = sat32(SAT_W'(prod >>> (FRAC_BITS - 1)) + SAT_W'(cimag_reg));

    // Both squares are non-negative, so the sum fits unsigned 64 bits.
    assign mag       = unsigned'(rr_reg) + unsigned'(prod);
    assign esc_hit   = mag > r2_reg;
    assign last_iter = iter_reg == ITER_W'(MAX_ITER - 1);

    assign count_v = esc_hit ? iter_reg : ITER_W'(MAX_ITER);
    assign count_w = 16'(count_v);
    assign rg_w    = count_w * 16'(RG_SCALE);
    assign b_w     = count_w * 16'(B_SCALE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MX;
                end
            end
            ST_MX:  state_next = ST_MY;
            ST_MY:  state_next = ST_R2;
            ST_R2:  state_next = ST_CR2;
            ST_CR2: state_next = ST_WX;
            ST_WX:
            begin
                if (div_done)
                begin
                    state_next = ST_DY;
                end
            end
            ST_DY:  state_next = ST_WY;
            ST_WY:
            begin
                if (div_done)
                begin
                    state_next = ST_RR;
                end
            end
            ST_RR:  state_next = ST_II;
            ST_II:  state_next = ST_RI;
            ST_RI:  state_next = ST_NEW;
            ST_NEW: state_next = ST_NR;
            ST_NR:  state_next = ST_NI;
            ST_NI:  state_next = ST_CHK;
            ST_CHK:
            begin
                if (esc_hit || last_iter)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NEW;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            done_reg    <= 1'b0;
            radius_reg  <= RADIUS_RST;
            creal_reg   <= CREAL_RST;
            cimag_reg   <= CIMAG_RST;
            fwidth_reg  <= FWIDTH_RST;
            fheight_reg <= FHEIGHT_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_CHK) && (esc_hit || last_iter);
            if (state_reg == ST_IDLE)
            begin
                iter_reg <= '0;
            end
            else if ((state_reg == ST_CHK) && !esc_hit && !last_iter)
            begin
                iter_reg <= iter_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ESCAPE_RADIUS: radius_reg  <= cfg_data[RAD_W-1:0];
                    CFG_CONST_REAL:    creal_reg   <= signed'(cfg_data);
                    CFG_CONST_IMAG:    cimag_reg   <= signed'(cfg_data);
                    CFG_FRAME_WIDTH:   fwidth_reg  <= cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT:  fheight_reg <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath captures, selected by sequencer step.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    px_reg <= pixel.pixel_x;
                    py_reg <= pixel.pixel_y;
                end
            end
            ST_R2:  numy_reg <= prod_num;
            ST_CR2: r2_reg   <= unsigned'(prod);
            ST_WX:
            begin
                if (div_done)
                begin
                    zr_reg <= z0_next;
                end
            end
            ST_WY:
            begin
                if (div_done)
                begin
                    zi_reg <= z0_next;
                end
            end
            ST_II, ST_NI: rr_reg <= prod;
            ST_RI:  d_reg <= rr_reg - prod;
            ST_NEW:
            begin
                zr_reg <= zr_next;
                zi_reg <= zi_next;
            end
            ST_CHK:
            begin
                d_reg <= rr_reg - prod;
                if (esc_hit || last_iter)
                begin
                    result_reg.iter_count <= count_w[ITER_OUT_W-1:0];
                    result_reg.escaped    <= esc_hit;
                    result_reg.red        <= rg_w[COLOR_W-1:0];
                    result_reg.green      <= rg_w[COLOR_W-1:0];
                    result_reg.blue       <= b_w[COLOR_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/jte_mul.sv
// ============================================================================
// jte_mul: shared signed multiplier
// One 32 x 32 signed multiply per clock; the full 64-bit product is
// registered and appears the cycle after the operands.
// ============================================================================
module jte_mul
    import jte_pkg::*;
(
    input  logic                     clk,
    input  logic signed [FX_W-1:0]   op_a,
    input  logic signed [FX_W-1:0]   op_b,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

// File: rtl/core/jte_div.sv
// ============================================================================
// jte_div: iterative unsigned divider for coordinate scaling
// Restoring division, two quotient bits per clock. A start loads the
// operands; done pulses for one cycle when the quotient is final.
// ============================================================================
module jte_div
    import jte_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic [NUM_W-1:0]     quo_reg;
    logic [NUM_W-1:0]     quo_next;
    logic [DIM_W-1:0]     rem_reg;
    logic [DIM_W-1:0]     rem_next;
    logic [DIM_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DIM_W:0]       trial;
    logic                 qbit;

    // The remainder stays below the divisor, so it always fits DIM_W bits.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        qbit     = 1'b0;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++)
        begin
            trial = {rem_next, quo_next[NUM_W-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                qbit  = 1'b1;
            end
            else
            begin
                qbit = 1'b0;
            end
            rem_next = trial[DIM_W-1:0];
            quo_next = {quo_next[NUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                cnt_reg <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: tb/tb_julia_escape_time_pixel.sv
// ============================================================================
// tb_julia_escape_time_pixel: self-checking bench for the Julia pixel block
// Sends pixel words through the start/busy handshake under several register
// settings, recomputes the escape count and colour of each pixel in Q4.28
// fixed point, and checks every result word against that value as it leaves.
// ============================================================================
module tb_julia_escape_time_pixel;
    import jte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITER = 20;
    localparam int RG_GAIN = 5;
    localparam int B_GAIN = 3;
    localparam int COORD_MAX = 4095;
    localparam int QUIET_CYCLES = 4;
    localparam int TAIL_WORDS = 100;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam longint FX_MAX = 64'sd2147483647;
    localparam longint FX_MIN = -64'sd2147483648;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] index;
        logic [FX_W-1:0]      data;
        pixel_t               pix;
    } frame_job_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    pixel_t               pixel = '0;
    logic                 busy;
    logic                 done;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FX_W-1:0]      cfg_data = '0;

    // Register copies used to work out the expected escape results.
    logic [RAD_W-1:0]       cur_radius = RADIUS_RST;
    logic signed [FX_W-1:0] cur_c_re = CREAL_RST;
    logic signed [FX_W-1:0] cur_c_im = CIMAG_RST;
    logic [DIM_W-1:0]       cur_width = FWIDTH_RST;
    logic [DIM_W-1:0]       cur_height = FHEIGHT_RST;

    frame_job_t frame_jobs[$];
    result_t    julia_results[$];
    int         pixels_total = 0;
    int         pixels_sent = 0;
    int         gap_left = 0;
    bit         gap_after_done = 1'b0;
    int         quiet = 0;
    int         errors = 0;
    int         cycles = 0;
    int         plan_w = FWIDTH_RST;
    int         plan_h = FHEIGHT_RST;

    julia_escape_time_pixel #(
        .MAX_ITER(MAX_ITER)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .pixel(pixel),
        .busy(busy),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_fx(longint v);
        if (v > FX_MAX)
        begin
            return FX_MAX;
        end
        if (v < FX_MIN)
        begin
            return FX_MIN;
        end
        return v;
    endfunction

    // Start value on one axis: floor(coord * 2R / size) - R, size 0 taken as 1.
    function automatic longint map_coord(logic [COORD_W-1:0] coord, logic [DIM_W-1:0] size);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        num = longint'(coord) * 2 * longint'(cur_radius);
        den = (size == '0) ? 64'd1 : 64'(size);
        q = num / den;
        return clamp_fx(longint'(q) - longint'(cur_radius));
    endfunction

    function automatic result_t julia_pixel_result(pixel_t pix);
        longint          zr;
        longint          zi;
        longint          rr;
        longint          ii;
        longint          ri;
        longint unsigned sq_r;
        longint unsigned sq_i;
        longint unsigned r2;
        int unsigned     count;
        bit              esc;
        result_t         res;
        zr = map_coord(pix.pixel_x, cur_width);
        zi = map_coord(pix.pixel_y, cur_height);
        r2 = longint'(cur_radius) * longint'(cur_radius);
        count = MAX_ITER;
        esc = 1'b0;
        for (int i = 0; i < MAX_ITER; i++)
        begin
            if (!esc)
            begin
                rr = zr * zr;
                ii = zi * zi;
                ri = zr * zi;
                zr = clamp_fx(((rr - ii) >>> FRAC_BITS) + longint'(cur_c_re));
                zi = clamp_fx((ri >>> (FRAC_BITS - 1)) + longint'(cur_c_im));
                sq_r = zr * zr;
                sq_i = zi * zi;
                if (sq_r + sq_i > r2)
                begin
                    count = i;
                    esc = 1'b1;
                end
            end
        end
        res.iter_count = ITER_OUT_W'(count);
        res.escaped = esc;
        res.red = COLOR_W'(count * RG_GAIN);
        res.green = COLOR_W'(count * RG_GAIN);
        res.blue = COLOR_W'(count * B_GAIN);
        return res;
    endfunction

    task automatic note_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("t=%0d ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Driver: register writes wait for an idle block, pixel words follow the handshake.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        frame_job_t job;
        logic       nxt_start;
        logic       nxt_we;
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            gap_left = 0;
            quiet = 0;
        end
        else
        begin
            nxt_start = start && busy;
            nxt_we = 1'b0;
            if (start && !busy)
            begin
                pixels_sent++;
                if (pixels_sent < pixels_total - TAIL_WORDS && (pixels_sent % 128) < 96
                    && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(1, 15);
                    gap_after_done = ($urandom_range(0, 1) == 1);
                end
            end
            quiet = (busy || start || done) ? 0 : quiet + 1;
            if (!nxt_start)
            begin
                if (gap_left != 0)
                begin
                    // Some gaps only run once the block has gone idle.
                    if (!gap_after_done || !busy)
                    begin
                        gap_left--;
                    end
                end
                else if (frame_jobs.size() != 0)
                begin
                    job = frame_jobs[0];
                    if (!job.is_cfg)
                    begin
                        nxt_start = 1'b1;
                        pixel <= job.pix;
                        void'(frame_jobs.pop_front());
                    end
                    else if (quiet >= QUIET_CYCLES && julia_results.size() == 0)
                    begin
                        nxt_we = 1'b1;
                        cfg_index <= job.index;
                        cfg_data <= job.data;
                        void'(frame_jobs.pop_front());
                    end
                end
            end
            start <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // Monitor: tracks register writes, queues expected words, checks result words.
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        result_t want;
        if (!rst_n)
        begin
            cur_radius = RADIUS_RST;
            cur_c_re = CREAL_RST;
            cur_c_im = CIMAG_RST;
            cur_width = FWIDTH_RST;
            cur_height = FHEIGHT_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ESCAPE_RADIUS: cur_radius = cfg_data[RAD_W-1:0];
                    CFG_CONST_REAL:    cur_c_re = cfg_data;
                    CFG_CONST_IMAG:    cur_c_im = cfg_data;
                    CFG_FRAME_WIDTH:   cur_width = cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT:  cur_height = cfg_data[DIM_W-1:0];
                    default:           ;
                endcase
            end
            if (done)
            begin
                if (julia_results.size() == 0)
                begin
                    errors++;
                    $display("t=%0d ns: result word %h with none expected", $time, result);
                end
                else
                begin
                    want = julia_results.pop_front();
                    note_field("iter_count", 8'(want.iter_count), 8'(result.iter_count));
                    note_field("escaped", 8'(want.escaped), 8'(result.escaped));
                    note_field("red", want.red, result.red);
                    note_field("green", want.green, result.green);
                    note_field("blue", want.blue, result.blue);
                end
            end
            if (start && !busy)
            begin
                julia_results.push_back(julia_pixel_result(pixel));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int clip_coord(int v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    task automatic add_pixel(int x, int y);
        frame_job_t job;
        job.is_cfg = 1'b0;
        job.index = '0;
        job.data = '0;
        job.pix.pixel_x = x[COORD_W-1:0];
        job.pix.pixel_y = y[COORD_W-1:0];
        frame_jobs.push_back(job);
        pixels_total++;
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] index, logic [FX_W-1:0] data);
        frame_job_t job;
        job.is_cfg = 1'b1;
        job.index = index;
        job.data = data;
        job.pix = '0;
        frame_jobs.push_back(job);
    endtask

    task automatic plan_config(logic [FX_W-1:0] radius, logic [FX_W-1:0] c_re,
                               logic [FX_W-1:0] c_im, logic [FX_W-1:0] width,
                               logic [FX_W-1:0] height);
        add_write(CFG_ESCAPE_RADIUS, radius);
        add_write(CFG_CONST_REAL, c_re);
        add_write(CFG_CONST_IMAG, c_im);
        add_write(CFG_FRAME_WIDTH, width);
        add_write(CFG_FRAME_HEIGHT, height);
        plan_w = int'(width[DIM_W-1:0]);
        plan_h = int'(height[DIM_W-1:0]);
    endtask

    // Corners, frame center, last pixel inside the frame and first one past it.
    task automatic plan_frame_points();
        int ex;
        int ey;
        ex = (plan_w == 0) ? 1 : plan_w;
        ey = (plan_h == 0) ? 1 : plan_h;
        add_pixel(0, 0);
        add_pixel(COORD_MAX, COORD_MAX);
        add_pixel(0, COORD_MAX);
        add_pixel(COORD_MAX, 0);
        add_pixel(clip_coord(ex / 2), clip_coord(ey / 2));
        add_pixel(clip_coord(ex - 1), clip_coord(ey - 1));
        add_pixel(clip_coord(ex), clip_coord(ey));
    endtask

    // Mostly pixels inside the frame, the rest anywhere in the coordinate range.
    task automatic plan_random_pixels(int n);
        int ex;
        int ey;
        int x;
        int y;
        ex = (plan_w == 0) ? 1 : plan_w;
        ey = (plan_h == 0) ? 1 : plan_h;
        repeat (n)
        begin
            x = ($urandom_range(0, 4) != 0) ? $urandom_range(0, clip_coord(ex - 1))
                                            : $urandom_range(0, COORD_MAX);
            y = ($urandom_range(0, 4) != 0) ? $urandom_range(0, clip_coord(ey - 1))
                                            : $urandom_range(0, COORD_MAX);
            add_pixel(x, y);
        end
    endtask

    initial
    begin
        logic [FX_W-1:0] radius;
        logic [FX_W-1:0] c_re;
        logic [FX_W-1:0] c_im;
        logic [FX_W-1:0] width;
        logic [FX_W-1:0] height;

        // Reset settings first; walking one bit through x and a zero through y.
        for (int b = 0; b < COORD_W; b++)
        begin
            add_pixel(1 << b, COORD_MAX ^ (1 << b));
        end
        plan_frame_points();
        plan_random_pixels(160);

        // Classic constant -0.8 + 0.156i on a small frame; the spare index must do nothing.
        plan_config(32'h2000_0000, -214748365, 41875931, 64, 48);
        add_write(CFG_SPARE, $urandom);
        plan_frame_points();
        plan_random_pixels(130);

        // Zero radius with zero sizes: z stays at zero and never escapes.
        plan_config(0, 0, 0, 0, 0);
        plan_frame_points();
        plan_random_pixels(40);

        // Zero radius with a nonzero constant: escapes on the first step.
        plan_config(0, 32'h0010_0000, $urandom, 0, 4096);
        plan_frame_points();
        plan_random_pixels(40);

        // Largest radius, extreme constants and a one-pixel width: x start values saturate.
        // Upper data bits beyond each register's width are set on purpose.
        plan_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_E001, 32'h0000_1FFF);
        plan_frame_points();
        plan_random_pixels(160);

        plan_config(32'h1000_0000, 76504105, 2684355, 4096, 4096);
        plan_frame_points();
        plan_random_pixels(130);

        repeat (3)
        begin
            radius = $urandom_range(0, 1) ? $urandom_range(32'h1000_0000, 32'h3000_0000)
                                          : $urandom;
            c_re = $urandom_range(0, 1) ? int'($urandom_range(0, 1 << 30)) - (1 << 29)
                                        : $urandom;
            c_im = $urandom_range(0, 1) ? int'($urandom_range(0, 1 << 30)) - (1 << 29)
                                        : $urandom;
            width = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(1, 256);
            height = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(1, 256);
            plan_config(radius, c_re, c_im, width, height);
            plan_frame_points();
            plan_random_pixels(130);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (frame_jobs.size() != 0 || start || busy || julia_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
